### hw/rtl/ggvc_pkg.sv
// Shared package of the go-to-goal velocity controller.
// Holds widths, codes, the configuration struct, the CORDIC angle table and
// the command and status structs between controller and datapath.
package ggvc_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int COORD_WIDTH_DEF  = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int SCALE_SH = 16;
    localparam int CNT_W    = 6;
    localparam int ZW       = 33;
    localparam int MD_W     = 23;
    localparam int MB_W     = 18;
    localparam int G_W      = 18;
    localparam int LIN_W    = 23;
    localparam int TURN_W   = 24;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;

    typedef enum logic [2:0] {
        ST_DRIVING = 3'd0,
        ST_ALREADY = 3'd1,
        ST_TOO_FAR = 3'd2,
        ST_JUST    = 3'd3,
        ST_RESTART = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        REG_MAX_DIST  = 3'd0,
        REG_MAX_BEAR  = 3'd1,
        REG_LIN_GAIN  = 3'd2,
        REG_ANG_GAIN  = 3'd3,
        REG_MIN_SPEED = 3'd4,
        REG_REACH     = 3'd5
    } t_reg_idx;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SUM_MD,
        OP_RR,
        OP_SQRT,
        OP_CORDIC,
        OP_CLAMP,
        OP_MUL_LD,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DIV_INIT,
        OP_DIV,
        OP_TURN,
        OP_RESULT
    } t_dp_op;

    typedef struct packed {
        logic [MD_W-1:0] max_distance;
        logic [MB_W-1:0] max_bearing;
        logic [G_W-1:0]  linear_gain;
        logic [G_W-1:0]  angular_gain;
        logic [MD_W-1:0] min_speed;
        logic [MD_W-1:0] reach_radius;
    } t_cfg;

    typedef struct packed {
        t_dp_op           op;
        t_status          st;
        logic [CNT_W-1:0] cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd;
        logic reached;
        logic too_far;
        logic in_reach;
        logic out_free;
    } t_dp_stat;

    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        logic [30:0] a;
        case (idx)
            5'd0:    a = 31'd843314856;
            5'd1:    a = 31'd497837829;
            5'd2:    a = 31'd263043836;
            5'd3:    a = 31'd133525158;
            5'd4:    a = 31'd67021686;
            5'd5:    a = 31'd33543515;
            5'd6:    a = 31'd16775850;
            5'd7:    a = 31'd8388437;
            5'd8:    a = 31'd4194282;
            5'd9:    a = 31'd2097149;
            5'd10:   a = 31'd1048575;
            5'd11:   a = 31'd524287;
            5'd12:   a = 31'd262143;
            5'd13:   a = 31'd131071;
            5'd14:   a = 31'd65535;
            5'd15:   a = 31'd32767;
            5'd16:   a = 31'd16383;
            5'd17:   a = 31'd8191;
            5'd18:   a = 31'd4095;
            5'd19:   a = 31'd2047;
            5'd20:   a = 31'd1023;
            5'd21:   a = 31'd511;
            5'd22:   a = 31'd255;
            5'd23:   a = 31'd127;
            default: a = 31'd0;
        endcase
        return a;
    endfunction

endpackage

### hw/rtl/ggvc_if.sv
// Valid/ready channel interfaces for goal items and twist result items.
// Depends on ggvc_pkg for default widths and output field widths.
interface ggvc_in_if #(
    parameter int COORD_WIDTH = ggvc_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic signed [COORD_WIDTH-1:0] goal_x;
    logic signed [COORD_WIDTH-1:0] goal_y;

    modport source(output valid, cmd, goal_x, goal_y, input ready);
    modport sink(input valid, cmd, goal_x, goal_y, output ready);
endinterface

interface ggvc_out_if ();
    logic                                 valid;
    logic                                 ready;
    logic        [ggvc_pkg::LIN_W-1:0]    linear_speed;
    logic signed [ggvc_pkg::TURN_W-1:0]   turn_rate;
    logic        [2:0]                    status;
    logic                                 reached;

    modport source(output valid, linear_speed, turn_rate, status, reached, input ready);
    modport sink(input valid, linear_speed, turn_rate, status, reached, output ready);
endinterface

### hw/rtl/ggvc_regs.sv
// APB-style configuration register file of the controller.
// Depends on ggvc_pkg for the register indexes and the t_cfg struct.
module ggvc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ggvc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ggvc_pkg::DATA_W-1:0]   pwdata,
    output logic [ggvc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output ggvc_pkg::t_cfg                o_cfg
);
    import ggvc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_distance <= MD_W'(655360);
            r_cfg.max_bearing  <= MB_W'(51446);
            r_cfg.linear_gain  <= G_W'(3277);
            r_cfg.angular_gain <= G_W'(13107);
            r_cfg.min_speed    <= MD_W'(1311);
            r_cfg.reach_radius <= MD_W'(3277);
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_MAX_DIST:  r_cfg.max_distance <= pwdata[MD_W-1:0];
                REG_MAX_BEAR:  r_cfg.max_bearing  <= pwdata[MB_W-1:0];
                REG_LIN_GAIN:  r_cfg.linear_gain  <= pwdata[G_W-1:0];
                REG_ANG_GAIN:  r_cfg.angular_gain <= pwdata[G_W-1:0];
                REG_MIN_SPEED: r_cfg.min_speed    <= pwdata[MD_W-1:0];
                REG_REACH:     r_cfg.reach_radius <= pwdata[MD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MAX_DIST:  prdata = DATA_W'(r_cfg.max_distance);
            REG_MAX_BEAR:  prdata = DATA_W'(r_cfg.max_bearing);
            REG_LIN_GAIN:  prdata = DATA_W'(r_cfg.linear_gain);
            REG_ANG_GAIN:  prdata = DATA_W'(r_cfg.angular_gain);
            REG_MIN_SPEED: prdata = DATA_W'(r_cfg.min_speed);
            REG_REACH:     prdata = DATA_W'(r_cfg.reach_radius);
            default:       prdata = '0;
        endcase
    end
endmodule

### hw/rtl/ggvc_ctrl.sv
// Sequencing state machine of the controller.
// Depends on ggvc_pkg; drives datapath ops and reads datapath status.
module ggvc_ctrl #(
    parameter int COORD_WIDTH  = ggvc_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = ggvc_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  ggvc_pkg::t_dp_stat i_stat,
    output logic               o_ready,
    output ggvc_pkg::t_dp_cmd  o_cmd
);
    import ggvc_pkg::*;

    localparam int PW = G_W + COORD_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_DECIDE, S_SQRT, S_COR, S_CHAIN, S_DIV, S_RESULT
    } t_state;

    t_state  r_state;
    t_dp_cmd r_cmd;

    assign o_ready = (r_state == S_IDLE);
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmd.op  <= OP_IDLE;
            r_cmd.st  <= ST_DRIVING;
            r_cmd.cnt <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_cmd.op <= OP_SQ_X;
                        r_state  <= S_SQ;
                    end else begin
                        r_cmd.op <= OP_IDLE;
                    end
                end
                S_SQ: begin
                    case (r_cmd.op)
                        OP_SQ_X:   r_cmd.op <= OP_SQ_Y;
                        OP_SQ_Y:   r_cmd.op <= OP_SUM_MD;
                        OP_SUM_MD: r_cmd.op <= OP_RR;
                        default: begin
                            r_cmd.op <= OP_IDLE;
                            r_state  <= S_DECIDE;
                        end
                    endcase
                end
                S_DECIDE: begin
                    r_cmd.cnt <= '0;
                    if (i_stat.cmd) begin
                        r_cmd.st <= ST_RESTART;
                        r_state  <= S_RESULT;
                    end else if (i_stat.reached) begin
                        r_cmd.st <= ST_ALREADY;
                        r_state  <= S_RESULT;
                    end else if (i_stat.too_far) begin
                        r_cmd.st <= ST_TOO_FAR;
                        r_state  <= S_RESULT;
                    end else if (i_stat.in_reach) begin
                        r_cmd.st <= ST_JUST;
                        r_state  <= S_RESULT;
                    end else begin
                        r_cmd.st <= ST_DRIVING;
                        r_cmd.op <= OP_SQRT;
                        r_state  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_cmd.cnt == CNT_W'(COORD_WIDTH - 1)) begin
                        r_cmd.cnt <= '0;
                        r_cmd.op  <= OP_CORDIC;
                        r_state   <= S_COR;
                    end else begin
                        r_cmd.cnt <= r_cmd.cnt + 1'b1;
                    end
                end
                S_COR: begin
                    if (r_cmd.cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                        r_cmd.cnt <= '0;
                        r_cmd.op  <= OP_CLAMP;
                        r_state   <= S_CHAIN;
                    end else begin
                        r_cmd.cnt <= r_cmd.cnt + 1'b1;
                    end
                end
                S_CHAIN: begin
                    case (r_cmd.op)
                        OP_CLAMP:  r_cmd.op <= OP_MUL_LD;
                        OP_MUL_LD: r_cmd.op <= OP_MUL_LO;
                        OP_MUL_LO: r_cmd.op <= OP_MUL_HI;
                        OP_MUL_HI: r_cmd.op <= OP_DIV_INIT;
                        OP_DIV_INIT: begin
                            r_cmd.op  <= OP_DIV;
                            r_cmd.cnt <= '0;
                            r_state   <= S_DIV;
                        end
                        default: begin
                            r_cmd.op <= OP_IDLE;
                            r_state  <= S_RESULT;
                        end
                    endcase
                end
                S_DIV: begin
                    if (r_cmd.cnt == CNT_W'(PW - 1)) begin
                        r_cmd.op <= OP_TURN;
                        r_state  <= S_CHAIN;
                    end else begin
                        r_cmd.cnt <= r_cmd.cnt + 1'b1;
                    end
                end
                S_RESULT: begin
                    if (i_stat.out_free) begin
                        r_cmd.op <= OP_RESULT;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cmd.op <= OP_IDLE;
                    end
                end
                default: begin
                    r_cmd.op <= OP_IDLE;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end
endmodule

### hw/rtl/ggvc_dp.sv
// Datapath: squares, digit-serial square root, CORDIC bearing, restoring
// divide, gains, saturation and the output register. Depends on ggvc_pkg.
module ggvc_dp #(
    parameter int FRAC_BITS   = ggvc_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = ggvc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic                                 i_cmd,
    input  logic signed [COORD_WIDTH-1:0]        i_goal_x,
    input  logic signed [COORD_WIDTH-1:0]        i_goal_y,
    input  ggvc_pkg::t_cfg                       i_cfg,
    input  ggvc_pkg::t_dp_cmd                    i_dcmd,
    output ggvc_pkg::t_dp_stat                   o_stat,
    input  logic                                 i_out_ready,
    output logic                                 o_valid,
    output logic        [ggvc_pkg::LIN_W-1:0]    o_linear_speed,
    output logic signed [ggvc_pkg::TURN_W-1:0]   o_turn_rate,
    output logic        [2:0]                    o_status,
    output logic                                 o_reached
);
    import ggvc_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int SW   = 2 * W;
    localparam int M2W  = 2 * MD_W;
    localparam int CW   = (SW > M2W) ? SW : M2W;
    localparam int XW   = W + SCALE_SH + 3;
    localparam int BW0  = (FRAC_BITS + 3 > MB_W + 1) ? FRAC_BITS + 3 : MB_W + 1;
    localparam int BW   = BW0 + 1;
    localparam int PW   = G_W + W;
    localparam int HL   = (PW + 1) / 2;
    localparam int HH   = PW - HL;
    localparam int NW   = PW + MB_W;
    localparam int TW   = G_W + MB_W + 2;

    localparam logic signed [ZW-1:0] RND = ZW'(1) <<< (29 - FRAC_BITS);
    localparam logic signed [TW-1:0] T_MAX = TW'((64'sd1 <<< (TURN_W - 1)) - 1);
    localparam logic signed [TW-1:0] T_MIN = -TW'(64'sd1 <<< (TURN_W - 1));

    logic                  r_cmd, r_reached, r_too_far, r_zero;
    logic signed [W-1:0]   r_x, r_y;
    logic [W-1:0]          ax, ay;
    logic [SW-1:0]         r_sx, r_sy, r_s, r_sh;
    logic [M2W-1:0]        r_md2, r_rr2;
    logic [W:0]            r_rem;
    logic [W-1:0]          r_root;
    logic [W+2:0]          sq_t, sq_trial;
    logic signed [XW-1:0]  r_cx, r_cy, xs, ys, dx, dy;
    logic signed [ZW-1:0]  r_z, z_at, zr;
    logic signed [BW-1:0]  b_full, mb_s;
    logic signed [MB_W:0]  r_b;
    logic [MB_W-1:0]       r_ab, diff;
    logic [PW-1:0]         r_p, r_dl, q_sh;
    logic [HL+MB_W-1:0]    r_plo;
    logic [HH+MB_W-1:0]    r_phi;
    logic [NW-1:0]         nsum;
    logic [MB_W-1:0]       r_drem;
    logic [MB_W:0]         dv_t;
    logic signed [TW-1:0]  tprod, tsh;
    logic [LIN_W-1:0]      r_lin, lin_sat;
    logic signed [TURN_W-1:0] r_turn;
    logic                  r_ov;
    logic [LIN_W-1:0]      r_lin_o;
    logic signed [TURN_W-1:0] r_turn_o;
    logic [2:0]            r_st_o;

    assign ax = r_x[W-1] ? W'(-r_x) : W'(r_x);
    assign ay = r_y[W-1] ? W'(-r_y) : W'(r_y);

    assign xs = XW'(r_x) <<< SCALE_SH;
    assign ys = XW'(r_y) <<< SCALE_SH;

    assign sq_t     = {r_rem, r_sh[SW-1:SW-2]};
    assign sq_trial = {1'b0, r_root, 2'b01};

    assign dx   = r_cy >>> i_dcmd.cnt[4:0];
    assign dy   = r_cx >>> i_dcmd.cnt[4:0];
    assign z_at = ZW'(signed'({1'b0, atan_q30(i_dcmd.cnt[4:0])}));

    assign zr     = (r_z + RND) >>> (30 - FRAC_BITS);
    assign b_full = r_zero ? '0 : zr[BW-1:0];
    assign mb_s   = BW'(signed'({1'b0, i_cfg.max_bearing}));
    assign diff   = i_cfg.max_bearing - r_ab;

    assign nsum = (NW'(r_phi) << HL) + NW'(r_plo);
    assign dv_t = {r_drem, r_dl[PW-1]};

    assign q_sh    = r_dl >> FRAC_BITS;
    assign lin_sat = (i_cfg.max_bearing == '0) ? '0 :
                     (q_sh > PW'({LIN_W{1'b1}})) ? {LIN_W{1'b1}} : q_sh[LIN_W-1:0];
    assign tprod   = TW'(signed'({1'b0, i_cfg.angular_gain})) * TW'(r_b);
    assign tsh     = tprod >>> FRAC_BITS;

    assign o_stat.cmd      = r_cmd;
    assign o_stat.reached  = r_reached;
    assign o_stat.too_far  = r_too_far;
    assign o_stat.in_reach = CW'(r_s) < CW'(r_rr2);
    assign o_stat.out_free = !r_ov || i_out_ready;

    assign o_valid        = r_ov;
    assign o_linear_speed = r_lin_o;
    assign o_turn_rate    = r_turn_o;
    assign o_status       = r_st_o;
    assign o_reached      = r_reached;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reached <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_dcmd.op == OP_RESULT) begin
                r_ov <= 1'b1;
                if (i_dcmd.st == ST_RESTART) begin
                    r_reached <= 1'b0;
                end else if (i_dcmd.st == ST_JUST) begin
                    r_reached <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd <= i_cmd;
            r_x   <= i_goal_x;
            r_y   <= i_goal_y;
        end
        case (i_dcmd.op)
            OP_SQ_X: r_sx <= SW'(ax * ax);
            OP_SQ_Y: r_sy <= SW'(ay * ay);
            OP_SUM_MD: begin
                r_s   <= r_sx + r_sy;
                r_md2 <= i_cfg.max_distance * i_cfg.max_distance;
            end
            OP_RR: begin
                r_rr2     <= i_cfg.reach_radius * i_cfg.reach_radius;
                r_too_far <= CW'(r_s) > CW'(r_md2);
                r_sh      <= r_s;
                r_rem     <= '0;
                r_root    <= '0;
                r_zero    <= (r_x == '0) && (r_y == '0);
                if (r_x < 0) begin
                    if (r_y >= 0) begin
                        r_cx <= ys;
                        r_cy <= -xs;
                        r_z  <= HALF_PI_Q30;
                    end else begin
                        r_cx <= -ys;
                        r_cy <= xs;
                        r_z  <= -HALF_PI_Q30;
                    end
                end else begin
                    r_cx <= xs;
                    r_cy <= ys;
                    r_z  <= '0;
                end
            end
            OP_SQRT: begin
                r_sh <= r_sh << 2;
                if (sq_t >= sq_trial) begin
                    r_rem  <= (W+1)'(sq_t - sq_trial);
                    r_root <= {r_root[W-2:0], 1'b1};
                end else begin
                    r_rem  <= sq_t[W:0];
                    r_root <= {r_root[W-2:0], 1'b0};
                end
            end
            OP_CORDIC: begin
                if (r_cy >= 0) begin
                    r_cx <= r_cx + dx;
                    r_cy <= r_cy - dy;
                    r_z  <= r_z + z_at;
                end else begin
                    r_cx <= r_cx - dx;
                    r_cy <= r_cy + dy;
                    r_z  <= r_z - z_at;
                end
            end
            OP_CLAMP: begin
                if (b_full > mb_s) begin
                    r_b  <= (MB_W+1)'(mb_s);
                    r_ab <= i_cfg.max_bearing;
                end else if (b_full < -mb_s) begin
                    r_b  <= (MB_W+1)'(-mb_s);
                    r_ab <= i_cfg.max_bearing;
                end else begin
                    r_b  <= b_full[MB_W:0];
                    r_ab <= b_full[BW-1] ? MB_W'(-b_full) : MB_W'(b_full);
                end
            end
            OP_MUL_LD: r_p <= PW'(i_cfg.linear_gain * r_root);
            OP_MUL_LO: r_plo <= r_p[HL-1:0] * diff;
            OP_MUL_HI: r_phi <= r_p[PW-1:HL] * diff;
            OP_DIV_INIT: begin
                r_drem <= nsum[NW-1:PW];
                r_dl   <= nsum[PW-1:0];
            end
            OP_DIV: begin
                if (dv_t >= {1'b0, i_cfg.max_bearing}) begin
                    r_drem <= MB_W'(dv_t - {1'b0, i_cfg.max_bearing});
                    r_dl   <= {r_dl[PW-2:0], 1'b1};
                end else begin
                    r_drem <= dv_t[MB_W-1:0];
                    r_dl   <= {r_dl[PW-2:0], 1'b0};
                end
            end
            OP_TURN: begin
                r_lin <= (lin_sat < i_cfg.min_speed) ? i_cfg.min_speed : lin_sat;
                if (tsh > T_MAX) begin
                    r_turn <= T_MAX[TURN_W-1:0];
                end else if (tsh < T_MIN) begin
                    r_turn <= T_MIN[TURN_W-1:0];
                end else begin
                    r_turn <= tsh[TURN_W-1:0];
                end
            end
            OP_RESULT: begin
                r_st_o <= i_dcmd.st;
                if (i_dcmd.st == ST_DRIVING) begin
                    r_lin_o  <= r_lin;
                    r_turn_o <= r_turn;
                end else begin
                    r_lin_o  <= '0;
                    r_turn_o <= '0;
                end
            end
            default: ;
        endcase
    end
endmodule

### hw/rtl/go_to_goal_velocity_controller_top.sv
// Go-to-goal velocity controller. One item at a time: after a driving step
// the next item is taken only once the bit-serial square root, the CORDIC
// loop and the restoring divide have run; the result is valid in the cycle
// after the controller is ready again. Other steps skip those three loops.
// A result waiting in the output register does not stop the next item from
// being taken, only from finishing. Synchronous active-low reset clears the
// reached flag, the sequencer and the registers to their defaults.
module go_to_goal_velocity_controller_top #(
    parameter int FRAC_BITS    = ggvc_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH  = ggvc_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = ggvc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ggvc_in_if.sink                       in_ch,
    ggvc_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ggvc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ggvc_pkg::DATA_W-1:0]   pwdata,
    output logic [ggvc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import ggvc_pkg::*;

    t_cfg     cfg;
    t_dp_cmd  dcmd;
    t_dp_stat dstat;
    logic     ready, accept;

    assign in_ch.ready = ready;
    assign accept      = in_ch.valid && ready;

    ggvc_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(cfg)
    );

    ggvc_ctrl #(.COORD_WIDTH(COORD_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept), .i_stat(dstat),
        .o_ready(ready), .o_cmd(dcmd)
    );

    ggvc_dp #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept), .i_cmd(in_ch.cmd),
        .i_goal_x(in_ch.goal_x), .i_goal_y(in_ch.goal_y), .i_cfg(cfg),
        .i_dcmd(dcmd), .o_stat(dstat), .i_out_ready(out_ch.ready),
        .o_valid(out_ch.valid), .o_linear_speed(out_ch.linear_speed),
        .o_turn_rate(out_ch.turn_rate), .o_status(out_ch.status),
        .o_reached(out_ch.reached)
    );
endmodule

### verif/tb_go_to_goal_velocity_controller_top.sv
// Self-checking testbench of the go-to-goal velocity controller top level.
// Drives goal items over the input channel and registers over APB, and checks
// each twist item against an in-bench fixed-point predictor. Needs ggvc_pkg and ggvc_if.
module tb_go_to_goal_velocity_controller_top;
    import ggvc_pkg::*;

    typedef struct packed {
        logic                    cmd;
        logic signed [23:0]      gx;
        logic signed [23:0]      gy;
    } t_goal;

    typedef struct packed {
        logic [LIN_W-1:0]         lin;
        logic signed [TURN_W-1:0] turn;
        t_status                  st;
        logic                     reached;
    } t_twist;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    ggvc_in_if  in_ch();
    ggvc_out_if out_ch();

    go_to_goal_velocity_controller_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    longint unsigned c_max_dist, c_max_bear, c_lin_gain, c_ang_gain, c_min_speed, c_reach;
    bit flag_reached;

    t_goal  goal_q[$];
    t_twist twist_q[$];
    int errors = 0;
    int n_sent = 0, n_seen = 0, n_taken = 0;
    int src_idle_pct = 0, snk_stall_pct = 0;
    bit snk_hold = 1'b0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint goal_bearing(longint x, longint y);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 65536;
        y = y * 65536;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = HALF_PI_Q30;
            end else begin
                t = x; x = -y; y = t; z = -HALF_PI_Q30;
            end
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(atan_q30(i[4:0]));
            end else begin
                x -= dx; y += dy; z -= longint'(atan_q30(i[4:0]));
            end
        end
        return asr(z + (64'sd1 <<< (29 - FRAC_BITS_DEF)), 30 - FRAC_BITS_DEF);
    endfunction

    function automatic t_twist predict_twist(t_goal g);
        t_twist r;
        longint x, y, b, mb, turn;
        longint unsigned ax, ay, s, d, ab, lin;
        x = g.gx;
        y = g.gy;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        s = ax * ax + ay * ay;
        lin = 0;
        turn = 0;
        if (g.cmd) begin
            flag_reached = 1'b0;
            r.st = ST_RESTART;
        end else if (flag_reached) begin
            r.st = ST_ALREADY;
        end else if (s > c_max_dist * c_max_dist) begin
            r.st = ST_TOO_FAR;
        end else if (s < c_reach * c_reach) begin
            flag_reached = 1'b1;
            r.st = ST_JUST;
        end else begin
            d = int_sqrt(s);
            mb = c_max_bear;
            b = goal_bearing(x, y);
            if (b > mb) b = mb;
            if (b < -mb) b = -mb;
            ab = b < 0 ? -b : b;
            if (c_max_bear != 0)
                lin = ((c_lin_gain * d * (c_max_bear - ab)) / c_max_bear) >> FRAC_BITS_DEF;
            if (lin > 64'd8388607) lin = 64'd8388607;
            if (lin < c_min_speed) lin = c_min_speed;
            turn = asr(longint'(c_ang_gain) * b, FRAC_BITS_DEF);
            if (turn > 8388607) turn = 8388607;
            if (turn < -8388608) turn = -8388608;
            r.st = ST_DRIVING;
        end
        r.lin = lin[LIN_W-1:0];
        r.turn = turn[TURN_W-1:0];
        r.reached = flag_reached;
        return r;
    endfunction

    // Input acceptance is seen at the rising edge, where the handshake happens.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            twist_q.push_back(predict_twist(goal_q.pop_front()));
            n_sent++;
        end
    end

    // Driver: presents the queue head and holds it until accepted.
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_ch.valid || n_sent != n_taken)) begin
            n_taken = n_sent;
            if (goal_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.cmd <= goal_q[0].cmd;
                in_ch.goal_x <= goal_q[0].gx;
                in_ch.goal_y <= goal_q[0].gy;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= !snk_hold && ($urandom_range(99) >= snk_stall_pct);
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_twist e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_seen++;
            if (twist_q.size() == 0) begin
                $error("twist item with nothing expected");
                errors++;
            end else begin
                e = twist_q.pop_front();
                if (out_ch.linear_speed !== e.lin) begin
                    $error("linear_speed exp %0d got %0d", e.lin, out_ch.linear_speed);
                    errors++;
                end
                if (out_ch.turn_rate !== e.turn) begin
                    $error("turn_rate exp %0d got %0d", e.turn, out_ch.turn_rate);
                    errors++;
                end
                if (out_ch.status !== e.st) begin
                    $error("status exp %0d got %0d", e.st, out_ch.status);
                    errors++;
                end
                if (out_ch.reached !== e.reached) begin
                    $error("reached exp %0d got %0d", e.reached, out_ch.reached);
                    errors++;
                end
            end
        end
    end

    task automatic apb_write(t_reg_idx idx, logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(4 * int'(idx)); pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_MAX_DIST:  c_max_dist  = val & 32'h7FFFFF;
            REG_MAX_BEAR:  c_max_bear  = val & 32'h3FFFF;
            REG_LIN_GAIN:  c_lin_gain  = val & 32'h3FFFF;
            REG_ANG_GAIN:  c_ang_gain  = val & 32'h3FFFF;
            REG_MIN_SPEED: c_min_speed = val & 32'h7FFFFF;
            default:       c_reach     = val & 32'h7FFFFF;
        endcase
    endtask

    task automatic drain();
        while (goal_q.size() > 0 || twist_q.size() > 0 || in_ch.valid) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'(int'($urandom_range(2000000)) - 1000000);
            default: return 24'(int'($urandom_range(20000)) - 10000);
        endcase
    endfunction

    task automatic add_goal(logic cmd, logic signed [23:0] gx, logic signed [23:0] gy);
        t_goal g;
        g.cmd = cmd; g.gx = gx; g.gy = gy;
        goal_q.push_back(g);
    endtask

    task automatic random_phase(int count);
        int m;
        for (int i = 0; i < count; i++) begin
            m = $urandom_range(2);
            add_goal($urandom_range(9) == 0, rand_coord(m), rand_coord(m));
        end
    endtask

    initial begin
        in_ch.valid = 1'b0; in_ch.cmd = 1'b0; in_ch.goal_x = '0; in_ch.goal_y = '0;
        out_ch.ready = 1'b0;
        c_max_dist = 655360; c_max_bear = 51446; c_lin_gain = 3277;
        c_ang_gain = 13107; c_min_speed = 1311; c_reach = 3277;
        flag_reached = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, quadrants, reach, restart, far goals.
        add_goal(1'b0, 24'sh7FFFFF, 24'sh7FFFFF);
        add_goal(1'b0, -24'sd65536, 24'sd0);
        add_goal(1'b0, -24'sd65536, 24'sd1000);
        add_goal(1'b0, -24'sd65536, -24'sd1000);
        add_goal(1'b0, 24'sd100000, 24'sd300000);
        add_goal(1'b0, 24'sd100000, -24'sd300000);
        add_goal(1'b0, 24'sd655360, 24'sd0);
        add_goal(1'b0, 24'sd10, 24'sd10);
        add_goal(1'b0, 24'sd100000, 24'sd0);
        add_goal(1'b1, 24'sh800000, 24'sh800000);
        add_goal(1'b0, 24'sh800000, 24'sh7FFFFF);
        drain();
        apb_write(REG_REACH, 0);
        apb_write(REG_MAX_DIST, 32'h7FFFFF);
        apb_write(REG_MAX_BEAR, 0);
        add_goal(1'b0, 24'sd0, 24'sd0);
        add_goal(1'b0, 24'sh7FFFFF, 24'sh800000);
        add_goal(1'b0, 24'sh800000, 24'sd0);
        drain();
        apb_write(REG_MAX_BEAR, 205887);
        apb_write(REG_LIN_GAIN, 262143);
        apb_write(REG_ANG_GAIN, 262143);
        apb_write(REG_MIN_SPEED, 32'h7FFFFF);
        add_goal(1'b0, 24'sh800000, 24'sh800000);
        add_goal(1'b0, 24'sd5000, -24'sd70000);
        drain();
        apb_write(REG_MIN_SPEED, 32'hFFFFFFFF);
        drain();
        apb_write(REG_MIN_SPEED, 0);
        add_goal(1'b0, 24'sh7FFFFF, 24'sd1);
        add_goal(1'b0, -24'sd300, 24'sd20000);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct  = (ph == 1) ? 55 : (ph == 3) ? 37 : 0;
            snk_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 37 : 0;
            apb_write(REG_MAX_DIST, $urandom_range(1, 2000000));
            apb_write(REG_MAX_BEAR, $urandom_range(1, 205887));
            apb_write(REG_LIN_GAIN, $urandom_range(262143));
            apb_write(REG_ANG_GAIN, $urandom_range(262143));
            apb_write(REG_MIN_SPEED, $urandom_range(70000));
            apb_write(REG_REACH, $urandom_range(30000));
            if (ph == 0) begin
                snk_hold = 1'b1;
                random_phase(20);
                repeat (800) @(negedge i_clk);
                snk_hold = 1'b0;
            end
            random_phase(95);
            drain();
        end

        $display("Ran %0d goal items, %0d twist items checked, over several register settings",
                 n_sent, n_seen);
        $display("and four idle/stall mixes including a long receiver hold-off.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

### go_to_goal_velocity_controller_top.f
hw/rtl/ggvc_pkg.sv
hw/rtl/ggvc_if.sv
hw/rtl/ggvc_regs.sv
hw/rtl/ggvc_ctrl.sv
hw/rtl/ggvc_dp.sv
hw/rtl/go_to_goal_velocity_controller_top.sv
verif/tb_go_to_goal_velocity_controller_top.sv
